[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

[hdl/iie_pkg.sv]
`timescale 1ns / 1ps

package iie_pkg;

  localparam int unsigned STORE_WORDS_DEFAULT = 1024;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W = 10;

  typedef enum logic [2:0] {
    MODE_NOOP   = 3'd0,
    MODE_IN     = 3'd1,
    MODE_OUT    = 3'd2,
    MODE_ASSIGN = 3'd3,
    MODE_CJMP   = 3'd4,
    MODE_JMP    = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ALU_COPY = 3'd0,
    ALU_ADD  = 3'd1,
    ALU_SUB  = 3'd2,
    ALU_MUL  = 3'd3,
    ALU_DIV  = 3'd4
  } alu_op_e;

  typedef enum logic [1:0] {
    COND_GT = 2'd0,
    COND_LT = 2'd1,
    COND_NE = 2'd2
  } cond_op_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_DIVZERO = 2'd1,
    STATUS_INVALID = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic [2:0]               mode;
    logic [IDX_W-1:0]         dest_index;
    logic [IDX_W-1:0]         src_a_index;
    logic [IDX_W-1:0]         src_b_index;
    logic [2:0]               alu_op;
    logic [1:0]               cond_op;
    logic signed [DATA_W-1:0] in_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_value;
    logic                     out_valid;
    logic                     jump_taken;
    logic [1:0]               status;
  } out_item_t;

  typedef struct packed {
    logic ir_load;
    logic clear_en;
    logic div_start;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic need_div;
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

[hdl/iie_ram.sv]
`timescale 1ns / 1ps

module iie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[hdl/iie_divider.sv]
`timescale 1ns / 1ps

`include "assert_macros.svh"

module iie_divider
  import iie_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic [DATA_W-1:0] quotient_o,
  output logic              busy_o
);

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] den_q, den_d;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    shifted = {rem_q, quo_q[DATA_W-1]};
    diff    = shifted - {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      den_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[DATA_W]) begin
        rem_d = diff[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign quotient_o = quo_q;
  assign busy_o     = busy_q;

  `ASSERT_NEVER(a_start_while_busy, clk_i, rst_ni, start_i && busy_q)

endmodule

[hdl/iie_datapath.sv]
`timescale 1ns / 1ps

module iie_datapath
  import iie_pkg::*;
#(
  parameter int unsigned STORE_WORDS = STORE_WORDS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t sts_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o
);

  localparam int unsigned AW = $clog2(STORE_WORDS);

  in_item_t            ir_q;
  logic                a_ok_q, b_ok_q, d_ok_q;
  logic                neg_q;
  logic [AW-1:0]       clr_cnt_q;
  logic                out_valid_q;
  out_item_t           out_item_q;

  logic [31:0]         ra_ext, rb_ext, wd_ext;
  logic [IDX_W-1:0]    ra_idx;
  logic [DATA_W-1:0]   rd_a, rd_b;
  logic signed [DATA_W-1:0] a, b;
  logic [DATA_W-1:0]   mag_a, mag_b, quo, div_res;
  logic signed [DATA_W-1:0] mul;
  out_item_t           res;
  logic                wr_ok;
  logic [DATA_W-1:0]   wdata;
  logic                need_div;
  logic                div_busy;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic                out_free;

  // out reads its variable through port A
  assign ra_idx = (in_item_i.mode == MODE_OUT) ? in_item_i.dest_index
                                                : in_item_i.src_a_index;
  assign ra_ext = 32'(ra_idx);
  assign rb_ext = 32'(in_item_i.src_b_index);
  assign wd_ext = 32'(ir_q.dest_index);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ir_load) begin
      ir_q   <= in_item_i;
      a_ok_q <= ra_ext < STORE_WORDS;
      b_ok_q <= rb_ext < STORE_WORDS;
      d_ok_q <= 32'(in_item_i.dest_index) < STORE_WORDS;
    end
    if (cmd_i.div_start) begin
      neg_q <= a[DATA_W-1] ^ b[DATA_W-1];
    end
  end

  assign ram_we    = cmd_i.clear_en || (cmd_i.commit && wr_ok && d_ok_q);
  assign ram_waddr = cmd_i.clear_en ? clr_cnt_q : wd_ext[AW-1:0];
  assign ram_wdata = cmd_i.clear_en ? '0 : wdata;

  iie_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STORE_WORDS)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .re_i     (cmd_i.ir_load),
    .raddr_a_i(ra_ext[AW-1:0]),
    .raddr_b_i(rb_ext[AW-1:0]),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  assign a     = a_ok_q ? rd_a : '0;
  assign b     = b_ok_q ? rd_b : '0;
  assign mag_a = a[DATA_W-1] ? (DATA_W'(0) - a) : a;
  assign mag_b = b[DATA_W-1] ? (DATA_W'(0) - b) : b;
  assign mul   = a * b;

  iie_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(mag_a),
    .divisor_i (mag_b),
    .quotient_o(quo),
    .busy_o    (div_busy)
  );

  assign div_res = neg_q ? (DATA_W'(0) - quo) : quo;

  always_comb begin
    res      = '0;
    res.status = STATUS_OK;
    wr_ok    = 1'b0;
    wdata    = '0;
    need_div = 1'b0;
    unique case (ir_q.mode)
      MODE_NOOP: begin
      end
      MODE_IN: begin
        wr_ok = 1'b1;
        wdata = ir_q.in_value;
      end
      MODE_OUT: begin
        res.out_value = a;
        res.out_valid = 1'b1;
      end
      MODE_ASSIGN: begin
        unique case (ir_q.alu_op)
          ALU_COPY: begin
            wr_ok = 1'b1;
            wdata = a;
          end
          ALU_ADD: begin
            wr_ok = 1'b1;
            wdata = a + b;
          end
          ALU_SUB: begin
            wr_ok = 1'b1;
            wdata = a - b;
          end
          ALU_MUL: begin
            wr_ok = 1'b1;
            wdata = mul;
          end
          ALU_DIV: begin
            if (b == '0) begin
              res.status = STATUS_DIVZERO;
            end else begin
              need_div = 1'b1;
              wr_ok    = 1'b1;
              wdata    = div_res;
            end
          end
          default: res.status = STATUS_INVALID;
        endcase
      end
      MODE_CJMP: begin
        unique case (ir_q.cond_op)
          COND_GT: res.jump_taken = !(a > b);
          COND_LT: res.jump_taken = !(a < b);
          COND_NE: res.jump_taken = !(a != b);
          default: res.status = STATUS_INVALID;
        endcase
      end
      MODE_JMP: res.jump_taken = 1'b1;
      default:  res.status = STATUS_INVALID;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_en) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_item_q <= res;
    end
  end

  assign sts_o.clear_done = clr_cnt_q == AW'(STORE_WORDS - 1);
  assign sts_o.need_div   = need_div;
  assign sts_o.div_busy   = div_busy;
  assign sts_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[hdl/iie_controller.sv]
`timescale 1ns / 1ps

`include "assert_macros.svh"

module iie_controller
  import iie_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output ctrl_cmd_t  cmd_o,
  input  dp_status_t sts_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (sts_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.ir_load = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (!sts_i.div_busy && sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  `ASSERT_CLK(a_load_then_exec, clk_i, rst_ni, cmd_o.ir_load |=> state_q == ST_EXEC)
  `ASSERT_CLK(a_commit_has_slot, clk_i, rst_ni, cmd_o.commit |-> sts_i.out_free)
  `ASSERT_CLK(a_start_then_busy, clk_i, rst_ni, cmd_o.div_start |=> sts_i.div_busy)

endmodule

[hdl/ir_instruction_executor.sv]
`timescale 1ns / 1ps

// channel | valid      | stall       | payload
// input   | in_valid_i | in_stall_o  | in_item_i  (in_item_t)
// output  | out_valid_o| out_stall_i | out_item_o (out_item_t)
//
// Most instructions first read their operands from the store, then execute and write.
// Divide uses the iterative divider, which produces one quotient bit per cycle.
// After reset the store is cleared one word per cycle, with the input stalled.
// A new item is accepted while a result waits in the output register; its result
// is held back until that register is taken.

module ir_instruction_executor
  import iie_pkg::*;
#(
  parameter int unsigned STORE_WORDS = STORE_WORDS_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  iie_controller u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  iie_datapath #(
    .STORE_WORDS(STORE_WORDS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

[tb/ir_instruction_executor_test.sv]
`timescale 1ns / 1ps

module ir_instruction_executor_test;
  import iie_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 1030;
  localparam int unsigned TAIL_CYCLES = 80;

  localparam logic [2:0] MODE_RSVD_6 = 3'd6;
  localparam logic [2:0] MODE_RSVD_7 = 3'd7;
  localparam logic [2:0] ALU_RSVD_5 = 3'd5;
  localparam logic [2:0] ALU_RSVD_7 = 3'd7;
  localparam logic [1:0] COND_RSVD = 2'd3;

  localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] WORD_NEG1 = 32'hFFFF_FFFF;
  localparam logic [IDX_W-1:0] IDX_TOP = {IDX_W{1'b1}};

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  ir_instruction_executor dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #10 clk_i = ~clk_i;

  logic [DATA_W-1:0] var_store [STORE_WORDS_DEFAULT];
  in_item_t          pending_instrs[$];
  out_item_t         expected_results[$];
  int unsigned       drain_points[$];
  int unsigned       mismatches = 0;
  int unsigned       instrs_sent = 0;
  int unsigned       cycle_count = 0;
  logic              in_took = 1'b0;

  function automatic out_item_t execute_instr(input in_item_t ins);
    out_item_t         res;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] ma;
    logic [DATA_W-1:0] mb;
    logic [DATA_W-1:0] q;
    logic              wr;
    res = '0;
    a = var_store[ins.src_a_index];
    b = var_store[ins.src_b_index];
    case (ins.mode)
      MODE_NOOP: ;
      MODE_IN: var_store[ins.dest_index] = ins.in_value;
      MODE_OUT: begin
        res.out_value = var_store[ins.dest_index];
        res.out_valid = 1'b1;
      end
      MODE_ASSIGN: begin
        wr = 1'b1;
        r = '0;
        case (ins.alu_op)
          ALU_COPY: r = a;
          ALU_ADD:  r = a + b;
          ALU_SUB:  r = a - b;
          ALU_MUL:  r = a * b;
          ALU_DIV: begin
            if (b == '0) begin
              res.status = STATUS_DIVZERO;
              wr = 1'b0;
            end else begin
              // magnitude divide keeps MIN / -1 wrapping to MIN
              ma = a[DATA_W-1] ? (32'd0 - a) : a;
              mb = b[DATA_W-1] ? (32'd0 - b) : b;
              q = ma / mb;
              r = (a[DATA_W-1] ^ b[DATA_W-1]) ? (32'd0 - q) : q;
            end
          end
          default: begin
            res.status = STATUS_INVALID;
            wr = 1'b0;
          end
        endcase
        if (wr) var_store[ins.dest_index] = r;
      end
      MODE_CJMP: begin
        case (ins.cond_op)
          COND_GT: res.jump_taken = !($signed(a) > $signed(b));
          COND_LT: res.jump_taken = !($signed(a) < $signed(b));
          COND_NE: res.jump_taken = !(a != b);
          default: res.status = STATUS_INVALID;
        endcase
      end
      MODE_JMP: res.jump_taken = 1'b1;
      default: res.status = STATUS_INVALID;
    endcase
    return res;
  endfunction

  task automatic log_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input longint expv, input longint actv);
    if (expv != actv) log_failure($sformatf("%s: expected %0d, got %0d", name, expv, actv));
  endtask

  task automatic add_instr(input logic [2:0] mode, input logic [IDX_W-1:0] dst,
                           input logic [IDX_W-1:0] sa, input logic [IDX_W-1:0] sb,
                           input logic [2:0] aop, input logic [1:0] cop,
                           input logic [DATA_W-1:0] val);
    in_item_t it;
    it.mode = mode;
    it.dest_index = dst;
    it.src_a_index = sa;
    it.src_b_index = sb;
    it.alu_op = aop;
    it.cond_op = cop;
    it.in_value = val;
    pending_instrs.push_back(it);
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return IDX_W'($urandom_range(0, 15));
    if (sel == 7) return IDX_TOP - IDX_W'($urandom_range(0, 3));
    return IDX_W'($urandom_range(0, 1023));
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return WORD_NEG1;
      3, 4: return DATA_W'($signed($urandom_range(0, 16)) - 8);
      default: return $urandom();
    endcase
  endfunction

  // sender: bursts with gaps, plus drain points where it waits for all results
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (drain_points.size() != 0 && instrs_sent == drain_points[0] &&
                   expected_results.size() != 0) begin
        in_valid_i <= 1'b0;
      end else if (pending_instrs.size() != 0) begin
        if (drain_points.size() != 0 && instrs_sent == drain_points[0])
          void'(drain_points.pop_front());
        in_item_i <= pending_instrs.pop_front();
        in_valid_i <= 1'b1;
        instrs_sent++;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: duty-cycle stall pattern, re-chosen every so often
  int unsigned stall_period = 1;
  int unsigned stall_duty = 0;
  int unsigned stall_phase = 0;
  int unsigned pattern_left = 0;

  always @(negedge clk_i) begin
    if (pattern_left == 0) begin
      pattern_left = $urandom_range(20, 200);
      stall_period = $urandom_range(1, 12);
      stall_duty = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, stall_period - 1);
      stall_phase = 0;
    end
    pattern_left--;
    out_stall_i <= (stall_phase < stall_duty);
    stall_phase = (stall_phase + 1) % stall_period;
  end

  // monitor: predict on accept, check on result take
  always @(posedge clk_i) begin
    out_item_t expv;
    in_took = rst_ni && in_valid_i && !in_stall_o;
    if (in_took) expected_results.push_back(execute_instr(in_item_i));
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        log_failure($sformatf("unexpected result %p", out_item_o));
      end else begin
        expv = expected_results.pop_front();
        check_field("out_value", $signed(expv.out_value), $signed(out_item_o.out_value));
        check_field("out_valid", expv.out_valid, out_item_o.out_valid);
        check_field("jump_taken", expv.jump_taken, out_item_o.jump_taken);
        check_field("status", expv.status, out_item_o.status);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    logic [95:0] raw;
    int unsigned sel;

    foreach (var_store[i]) var_store[i] = '0;

    // directed
    add_instr(MODE_IN, 10'd0, 10'd0, 10'd0, ALU_COPY, COND_GT, WORD_MAX);
    add_instr(MODE_IN, 10'd1, 10'd0, 10'd0, ALU_COPY, COND_GT, WORD_MIN);
    add_instr(MODE_IN, 10'd2, 10'd0, 10'd0, ALU_COPY, COND_GT, WORD_NEG1);
    add_instr(MODE_IN, 10'd3, 10'd0, 10'd0, ALU_COPY, COND_GT, '0);
    add_instr(MODE_IN, IDX_TOP, IDX_TOP, IDX_TOP, ALU_COPY, COND_GT, 32'd1);
    add_instr(MODE_IN, 10'd10, 10'd0, 10'd0, ALU_COPY, COND_GT, -32'sd7);
    add_instr(MODE_IN, 10'd11, 10'd0, 10'd0, ALU_COPY, COND_GT, 32'd2);
    add_instr(MODE_OUT, IDX_TOP, 10'd0, 10'd0, ALU_COPY, COND_GT, '0);
    add_instr(MODE_OUT, 10'd1, 10'd0, 10'd0, ALU_COPY, COND_GT, '0);
    add_instr(MODE_ASSIGN, 10'd4, 10'd0, 10'd0, ALU_ADD, COND_GT, '0);
    add_instr(MODE_ASSIGN, 10'd5, 10'd1, 10'd0, ALU_SUB, COND_GT, '0);
    add_instr(MODE_ASSIGN, 10'd6, 10'd0, 10'd0, ALU_MUL, COND_GT, '0);
    add_instr(MODE_ASSIGN, 10'd7, 10'd1, 10'd2, ALU_DIV, COND_GT, '0);
    add_instr(MODE_ASSIGN, 10'd8, 10'd0, 10'd3, ALU_DIV, COND_GT, '0);
    add_instr(MODE_ASSIGN, 10'd12, 10'd10, 10'd11, ALU_DIV, COND_GT, '0);
    add_instr(MODE_ASSIGN, 10'd9, IDX_TOP, 10'd0, ALU_COPY, COND_GT, '0);
    add_instr(MODE_ASSIGN, 10'd9, 10'd0, 10'd1, ALU_RSVD_5, COND_GT, '0);
    add_instr(MODE_ASSIGN, 10'd9, 10'd0, 10'd1, ALU_RSVD_7, COND_GT, '0);
    add_instr(MODE_CJMP, 10'd0, 10'd0, 10'd1, ALU_COPY, COND_GT, '0);
    add_instr(MODE_CJMP, 10'd0, 10'd0, 10'd1, ALU_COPY, COND_LT, '0);
    add_instr(MODE_CJMP, 10'd0, 10'd3, 10'd3, ALU_COPY, COND_NE, '0);
    add_instr(MODE_CJMP, 10'd0, 10'd0, 10'd1, ALU_COPY, COND_RSVD, '0);
    add_instr(MODE_JMP, 10'd0, 10'd0, 10'd0, ALU_COPY, COND_GT, '0);
    add_instr(MODE_RSVD_6, 10'd4, 10'd0, 10'd0, ALU_COPY, COND_GT, WORD_MAX);
    add_instr(MODE_RSVD_7, 10'd4, 10'd0, 10'd0, ALU_COPY, COND_GT, WORD_MAX);
    add_instr(MODE_NOOP, IDX_TOP, IDX_TOP, IDX_TOP, ALU_RSVD_7, COND_RSVD, WORD_NEG1);
    add_instr(MODE_OUT, 10'd4, 10'd0, 10'd0, ALU_COPY, COND_GT, '0);
    add_instr(MODE_OUT, 10'd7, 10'd0, 10'd0, ALU_COPY, COND_GT, '0);
    add_instr(MODE_OUT, 10'd8, 10'd0, 10'd0, ALU_COPY, COND_GT, '0);
    add_instr(MODE_OUT, 10'd12, 10'd0, 10'd0, ALU_COPY, COND_GT, '0);

    // random: unused fields carry noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      raw = {$urandom(), $urandom(), $urandom()};
      it = in_item_t'(raw[$bits(in_item_t)-1:0]);
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        it.mode = MODE_IN;
        it.dest_index = pick_index();
        it.in_value = pick_value();
      end else if (sel < 45) begin
        it.mode = MODE_OUT;
        it.dest_index = pick_index();
      end else if (sel < 75) begin
        it.mode = MODE_ASSIGN;
        it.dest_index = pick_index();
        it.src_a_index = pick_index();
        it.src_b_index = pick_index();
        it.alu_op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
      end else if (sel < 88) begin
        it.mode = MODE_CJMP;
        it.src_a_index = pick_index();
        it.src_b_index = ($urandom_range(0, 4) == 0) ? it.src_a_index : pick_index();
        it.cond_op = ($urandom_range(0, 9) == 0) ? COND_RSVD : 2'($urandom_range(0, 2));
      end else if (sel < 92) begin
        it.mode = MODE_JMP;
      end else if (sel < 95) begin
        it.mode = MODE_NOOP;
      end else begin
        it.mode = 3'($urandom_range(0, 7));
      end
      pending_instrs.push_back(it);
    end

    drain_points.push_back(400);
    drain_points.push_back(800);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_instrs.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
